@@ rtl/core/ksi_pkg.sv @@
// ----------------------------------------------------------------------------
// ksi_pkg: shared types and constants of the keyframe spline interpolator
// Keyframe record, command and result transactions, controller states,
// function, status and mode codes, saturation helpers.
// ----------------------------------------------------------------------------
package ksi_pkg;

	localparam int MAX_KEYS = 16;
	localparam int IDX_W    = $clog2(MAX_KEYS);
	localparam int CNT_W    = $clog2(MAX_KEYS + 1);

	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [16:0] HALF_Q16 = 17'd32768;
	localparam logic [15:0] TEN_MAX = 16'd32768;

	// command functions
	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_SETTEN = 2'd1;
	localparam logic [1:0] FUNC_INTERP = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_FULL  = 3'd2;
	localparam logic [2:0] ST_RANGE = 3'd3;
	localparam logic [2:0] ST_ZERO  = 3'd4;

	// interpolation modes
	localparam logic [2:0] MODE_LINEAR = 3'd0;
	localparam logic [2:0] MODE_IN     = 3'd1;
	localparam logic [2:0] MODE_OUT    = 3'd2;
	localparam logic [2:0] MODE_INOUT  = 3'd3;
	localparam logic [2:0] MODE_STEP   = 3'd4;
	localparam logic [2:0] MODE_SPLINE = 3'd5;

	typedef struct packed {
		logic        [1:0]  func;
		logic signed [31:0] item_time;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] scale_z;
		logic        [15:0] tension_in;
		logic        [3:0]  key_index;
	} cmd_t;

	typedef struct packed {
		logic        [2:0]  status;
		logic signed [31:0] out_time;
		logic signed [31:0] out_pos_x;
		logic signed [31:0] out_pos_y;
		logic signed [31:0] out_pos_z;
		logic signed [31:0] out_scale_x;
		logic signed [31:0] out_scale_y;
		logic signed [31:0] out_scale_z;
		logic        [15:0] out_tension;
	} res_t;

	// one stored keyframe; component 0 is x
	typedef struct packed {
		logic signed [31:0] time_v;
		logic [2:0][31:0]   pos;
		logic [2:0][31:0]   scale;
		logic [15:0]        ten;
	} key_t;

	// coefficients shared by all component lanes
	typedef struct packed {
		logic signed [17:0] alpha;
		logic signed [17:0] h1;
		logic signed [17:0] h2;
		logic signed [17:0] h3;
		logic signed [17:0] h4;
		logic signed [17:0] f;
		logic               spline;
		logic               k0;
		logic               klast;
	} lane_coef_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DUR, S_DUR2, S_MOD, S_SRCH, S_F1, S_F2, S_F3, S_F4, S_F5,
		S_FRAC, S_SQ, S_CUBE, S_H, S_LANE
	} state_t;

	localparam logic signed [55:0] SAT_MAX = 56'sd2147483647;
	localparam logic signed [55:0] SAT_MIN = -56'sd2147483648;

	function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX) r = 32'sh7FFF_FFFF;
		else if (v < SAT_MIN) r = 32'sh8000_0000;
		else r = 32'(v);
		return r;
	endfunction

	function automatic logic [31:0] abs32(input logic signed [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

endpackage

@@ rtl/core/ksi_table.sv @@
// ----------------------------------------------------------------------------
// ksi_table: keyframe store
// Time-ordered keyframe registers with shifting insert, tension update,
// one registered read port and a parallel segment search.
// ----------------------------------------------------------------------------
module ksi_table import ksi_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    ins_en,
	input  key_t                    ins_key,
	input  logic                    ten_en,
	input  logic [IDX_W-1:0]        ten_idx,
	input  logic [15:0]             ten_val,
	input  logic [IDX_W-1:0]        rd_idx,
	output key_t                    rd_key,
	input  logic signed [33:0]      srch_w,
	output logic [IDX_W-1:0]        srch_k,
	output logic [CNT_W-1:0]        count
);

	key_t               keys_q [MAX_KEYS];
	logic [CNT_W-1:0]   count_q;
	logic [MAX_KEYS-1:0] gt;
	logic [MAX_KEYS-1:0] moved;
	logic               found;

	assign count = count_q;

	// entries later than the new time move up one place
	always_comb begin
		for (int i = 0; i < MAX_KEYS; i++) begin
			gt[i] = (CNT_W'(i) < count_q) && (keys_q[i].time_v > ins_key.time_v);
		end
		moved[0] = 1'b0;
		for (int i = 1; i < MAX_KEYS; i++) begin
			moved[i] = gt[i-1];
		end
	end

	// storage and read port
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_KEYS; i++) begin
			if (ins_en) begin
				if (moved[i]) keys_q[i] <= keys_q[(i > 0) ? i - 1 : 0];
				else if (gt[i] || CNT_W'(i) == count_q) keys_q[i] <= ins_key;
			end else if (ten_en && ten_idx == IDX_W'(i)) begin
				keys_q[i].ten <= ten_val;
			end
		end
		rd_key <= keys_q[rd_idx];
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ins_en) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// first segment that holds the query time
	always_comb begin
		srch_k = '0;
		found  = 1'b0;
		for (int i = 0; i < MAX_KEYS - 1; i++) begin
			if (!found && CNT_W'(i + 1) < count_q &&
			    srch_w >= 34'(keys_q[i].time_v) && srch_w <= 34'(keys_q[i+1].time_v)) begin
				srch_k = IDX_W'(i);
				found  = 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/ksi_div.sv @@
// ----------------------------------------------------------------------------
// ksi_div: shared restoring divider
// One quotient bit per cycle; used for the time wrap remainder and for the
// segment fraction.
// ----------------------------------------------------------------------------
module ksi_div import ksi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [33:0] init_rem,
	input  logic [31:0] dvd,
	input  logic [32:0] dvs,
	input  logic [5:0]  nsteps,
	output logic [33:0] rem,
	output logic [15:0] quo,
	output logic        done
);

	logic [33:0] rem_q;
	logic [31:0] dvd_q;
	logic [32:0] dvs_q;
	logic [15:0] quo_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [33:0] trial;
	logic        ge;

	assign rem  = rem_q;
	assign quo  = quo_q;
	assign done = done_q;

	// one trial subtraction
	assign trial = {rem_q[32:0], dvd_q[31]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= init_rem;
			dvd_q <= dvd;
			dvs_q <= dvs;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? trial - {1'b0, dvs_q} : trial;
			dvd_q <= {dvd_q[30:0], 1'b0};
			quo_q <= {quo_q[14:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= nsteps;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ rtl/core/ksi_lane.sv @@
// ----------------------------------------------------------------------------
// ksi_lane: one component lane
// Shared multiplier with a step sequence: tangents, Hermite sum, linear
// blend of position and of scale.
// ----------------------------------------------------------------------------
module ksi_lane import ksi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  lane_coef_t         coef,
	input  logic signed [31:0] p0,
	input  logic signed [31:0] p1,
	input  logic signed [31:0] p2,
	input  logic signed [31:0] p3,
	input  logic signed [31:0] s1,
	input  logic signed [31:0] s2,
	output logic signed [31:0] pos,
	output logic signed [31:0] scale,
	output logic               done
);

	logic [2:0]         st_q, st_s1;
	logic               run_q, vld_s1, done_q;
	logic signed [33:0] pe0, pe3;
	logic signed [34:0] opa;
	logic signed [17:0] opb;
	logic signed [52:0] prod_s1;
	logic signed [34:0] m1_q, m2_q;
	logic signed [55:0] acc_q;
	logic signed [31:0] lin_q, pos_q, scl_q;

	assign pos   = pos_q;
	assign scale = scl_q;
	assign done  = done_q;

	// phantom end points
	always_comb begin
		pe0 = coef.k0 ? (34'(p1) + 34'(p1) - 34'(p2)) : 34'(p0);
		pe3 = (!coef.k0 && coef.klast) ? (34'(p2) + 34'(p2) - 34'(p1)) : 34'(p3);
	end

	// operand select per step
	always_comb begin
		case (st_q)
			3'd0: begin opa = 35'(p2) - 35'(pe0); opb = coef.alpha; end
			3'd1: begin opa = 35'(pe3) - 35'(p1); opb = coef.alpha; end
			3'd2: begin opa = 35'(p1);            opb = coef.h1;    end
			3'd3: begin opa = 35'(p2);            opb = coef.h2;    end
			3'd4: begin opa = m1_q;               opb = coef.h3;    end
			3'd5: begin opa = m2_q;               opb = coef.h4;    end
			3'd6: begin opa = 35'(p2) - 35'(p1);  opb = coef.f;     end
			default: begin opa = 35'(s2) - 35'(s1); opb = coef.f; end
		endcase
	end

	// multiply, then consume the registered product in the next cycle
	always_ff @(posedge clk) begin
		prod_s1 <= opa * opb;
		if (vld_s1) begin
			case (st_s1)
				3'd0: m1_q <= 35'(prod_s1 >>> 16);
				3'd1: m2_q <= 35'(prod_s1 >>> 16);
				3'd2: acc_q <= 56'(prod_s1);
				3'd3, 3'd4, 3'd5: acc_q <= acc_q + 56'(prod_s1);
				3'd6: lin_q <= 32'(35'(p1) + 35'(prod_s1 >>> 16));
				default: begin
					scl_q <= 32'(35'(s1) + 35'(prod_s1 >>> 16));
					pos_q <= coef.spline ? sat32(acc_q >>> 16) : lin_q;
				end
			endcase
		end
	end

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= '0;
			run_q  <= 1'b0;
			st_s1  <= '0;
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			st_s1  <= st_q;
			vld_s1 <= run_q;
			done_q <= vld_s1 && st_s1 == 3'd7;
			if (go) begin
				st_q  <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				st_q <= st_q + 3'd1;
				if (st_q == 3'd7) run_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/keyframe_spline_interpolator.sv @@
// ----------------------------------------------------------------------------
// keyframe_spline_interpolator: keyframe table with eased / Catmull-Rom query
// Sequencer, divider, three component lanes and the result merge.
//
//  channel   | signals               | handshake
//  ----------+-----------------------+------------------------------------
//  command   | cmd                   | start & !busy
//  config    | cfg_wdata             | cfg_we (mode register)
//  result    | result                | done, one cycle, no backpressure
//
// Insert, set tension, empty table and unused codes: done rises at the edge
// that accepts the command. A single-key query ends with the read of the
// last key; a full query reads the last key time, runs the 32-step wrap
// division, searches and reads keys, runs the 16-step fraction division,
// forms the basis and runs the lanes. Zero duration skips the wrap division.
// One transaction at a time; busy covers it. Reset clears key count and mode.
// ----------------------------------------------------------------------------
module keyframe_spline_interpolator import ksi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  cmd_t       cmd,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata,
	output logic       done,
	output res_t       result
);

	state_t             state_q, state_d;
	logic [2:0]         mode_q;
	logic               done_q;
	res_t               res_q;
	res_t               res_imm;
	cmd_t               cmd_q;
	logic               accept;

	// table
	key_t               ins_key, rd_key;
	logic               ins_en, ten_en;
	logic [IDX_W-1:0]   rd_idx, srch_k;
	logic [CNT_W-1:0]   count;
	logic [15:0]        ten_clamp;

	// divider
	logic               div_start, div_done;
	logic [33:0]        div_init, div_rem;
	logic [31:0]        div_dvd;
	logic [32:0]        div_dvs;
	logic [5:0]         div_steps;
	logic [15:0]        div_quo;

	// query datapath
	logic signed [31:0] dur_q;
	logic signed [33:0] w_q, ws, rm34;
	logic [IDX_W-1:0]   k_q, i0, i3;
	key_t               e0_q, e1_q, e2_q, e3_q;
	logic [2:0]         status_q;
	logic [16:0]        u_q, r_u, x_sq;
	logic [33:0]        sq_q;
	logic [50:0]        u3_q;
	logic [17:0]        f_c;
	logic signed [17:0] f_q, dten, tk18, bt;
	logic signed [35:0] btp_q, tp_q;
	logic signed [32:0] seg;
	logic signed [34:0] diff;
	logic               zero_c, frac_go;
	logic signed [52:0] a3, e2w, uw, t1, t2, t3, t4;
	lane_coef_t         coef_q, coef_d;
	logic               lane_go;
	logic [2:0]         lane_done;
	logic signed [31:0] lane_pos [3];
	logic signed [31:0] lane_scl [3];

	localparam logic signed [52:0] E3 = 53'sh1_0000_0000_0000;

	assign busy   = state_q != S_IDLE;
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = res_q;

	// command decode into the table
	assign ten_clamp = (cmd.tension_in > TEN_MAX) ? TEN_MAX : cmd.tension_in;
	always_comb begin
		ins_key.time_v = cmd.item_time;
		ins_key.pos    = {cmd.pos_z, cmd.pos_y, cmd.pos_x};
		ins_key.scale  = {cmd.scale_z, cmd.scale_y, cmd.scale_x};
		ins_key.ten    = ten_clamp;
	end
	assign ins_en = accept && cmd.func == FUNC_INSERT && count < CNT_W'(MAX_KEYS);
	assign ten_en = accept && cmd.func == FUNC_SETTEN && {1'b0, cmd.key_index} < count;

	// immediate result of a command that needs no query
	always_comb begin
		res_imm = '0;
		if (cmd.func == FUNC_INSERT && count >= CNT_W'(MAX_KEYS)) res_imm.status = ST_FULL;
		else if (cmd.func == FUNC_SETTEN && {1'b0, cmd.key_index} >= count)
			res_imm.status = ST_RANGE;
		else if (cmd.func == FUNC_INTERP && count == '0) res_imm.status = ST_EMPTY;
	end

	ksi_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ins_en  (ins_en),
		.ins_key (ins_key),
		.ten_en  (ten_en),
		.ten_idx (cmd.key_index),
		.ten_val (ten_clamp),
		.rd_idx  (rd_idx),
		.rd_key  (rd_key),
		.srch_w  (w_q),
		.srch_k  (srch_k),
		.count   (count)
	);

	ksi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.init_rem (div_init),
		.dvd      (div_dvd),
		.dvs      (div_dvs),
		.nsteps   (div_steps),
		.rem      (div_rem),
		.quo      (div_quo),
		.done     (div_done)
	);

	// neighbor indexes
	assign i0 = (k_q == '0) ? '0 : k_q - IDX_W'(1);
	assign i3 = ({1'b0, k_q} + CNT_W'(2) < count) ? k_q + IDX_W'(2) : k_q + IDX_W'(1);

	// segment length, offset and fraction decision
	always_comb begin
		seg     = 33'(e2_q.time_v) - 33'(e1_q.time_v);
		diff    = 35'(w_q) - 35'(e1_q.time_v);
		zero_c  = dur_q == 0 || seg == 0;
		frac_go = !zero_c && diff > 0 && diff < 35'(seg);
	end

	// wrapped time from the remainder
	always_comb begin
		rm34 = $signed({2'b00, div_rem[31:0]});
		ws   = cmd_q.item_time[31] ? -rm34 : rm34;
		if (ws < 0) ws = ws + 34'(dur_q);
	end

	// easing
	always_comb begin
		r_u = ONE_Q16 - u_q;
		case (mode_q)
			MODE_OUT:   x_sq = r_u;
			MODE_INOUT: x_sq = (u_q < HALF_Q16) ? u_q : r_u;
			default:    x_sq = u_q;
		endcase
		case (mode_q)
			MODE_IN:    f_c = 18'(sq_q >> 16);
			MODE_OUT:   f_c = 18'(ONE_Q16) - 18'(sq_q >> 16);
			MODE_INOUT: f_c = (u_q < HALF_Q16) ? 18'(sq_q >> 15) : 18'(ONE_Q16) - 18'(sq_q >> 15);
			MODE_STEP:  f_c = (u_q < ONE_Q16) ? 18'd0 : 18'(ONE_Q16);
			default:    f_c = 18'(u_q);
		endcase
	end

	// Hermite basis and tangent factor
	always_comb begin
		a3   = $signed({2'b00, u3_q});
		e2w  = $signed({3'b000, sq_q, 16'h0000});
		uw   = $signed({4'h0, u_q, 32'h0000_0000});
		t1   = a3 + a3 - (e2w + e2w + e2w) + E3;
		t2   = (e2w + e2w + e2w) - (a3 + a3);
		t3   = a3 - (e2w + e2w) + uw;
		t4   = a3 - e2w;
		tk18 = $signed({2'b00, e1_q.ten});
		dten = $signed({2'b00, e2_q.ten}) - tk18;
		bt   = tk18 + 18'(btp_q >>> 16);
		coef_d.alpha  = $signed({2'b00, TEN_MAX}) - bt;
		coef_d.h1     = 18'(t1 >>> 32);
		coef_d.h2     = 18'(t2 >>> 32);
		coef_d.h3     = 18'(t3 >>> 32);
		coef_d.h4     = 18'(t4 >>> 32);
		coef_d.f      = f_q;
		coef_d.spline = mode_q == MODE_SPLINE;
		coef_d.k0     = k_q == '0;
		coef_d.klast  = {1'b0, k_q} + CNT_W'(2) >= count;
	end

	// component lanes
	for (genvar c = 0; c < 3; c++) begin : g_lane
		ksi_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.go     (lane_go),
			.coef   (coef_q),
			.p0     ($signed(e0_q.pos[c])),
			.p1     ($signed(e1_q.pos[c])),
			.p2     ($signed(e2_q.pos[c])),
			.p3     ($signed(e3_q.pos[c])),
			.s1     ($signed(e1_q.scale[c])),
			.s2     ($signed(e2_q.scale[c])),
			.pos    (lane_pos[c]),
			.scale  (lane_scl[c]),
			.done   (lane_done[c])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept && cmd.func == FUNC_INTERP && count != '0) state_d = S_DUR;
			S_DUR:  state_d = S_DUR2;
			S_DUR2: begin
				if (count == CNT_W'(1)) state_d = S_IDLE;
				else if (rd_key.time_v == 0) state_d = S_SRCH;
				else state_d = S_MOD;
			end
			S_MOD:  if (div_done) state_d = S_SRCH;
			S_SRCH: state_d = S_F1;
			S_F1:   state_d = S_F2;
			S_F2:   state_d = S_F3;
			S_F3:   state_d = S_F4;
			S_F4:   state_d = S_F5;
			S_F5:   state_d = frac_go ? S_FRAC : S_SQ;
			S_FRAC: if (div_done) state_d = S_SQ;
			S_SQ:   state_d = S_CUBE;
			S_CUBE: state_d = S_H;
			S_H:    state_d = S_LANE;
			S_LANE: if (lane_done[0]) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		rd_idx    = '0;
		div_start = 1'b0;
		div_init  = '0;
		div_dvd   = '0;
		div_dvs   = '0;
		div_steps = 6'd32;
		lane_go   = 1'b0;
		case (state_q)
			S_DUR: rd_idx = IDX_W'(count - CNT_W'(1));
			S_DUR2: begin
				div_start = count != CNT_W'(1) && rd_key.time_v != 0;
				div_dvd   = abs32(cmd_q.item_time);
				div_dvs   = {1'b0, abs32(rd_key.time_v)};
			end
			S_F1: rd_idx = k_q;
			S_F2: rd_idx = k_q + IDX_W'(1);
			S_F3: rd_idx = i0;
			S_F4: rd_idx = i3;
			S_F5: begin
				div_start = frac_go;
				div_init  = 34'(diff);
				div_dvs   = 33'(seg);
				div_steps = 6'd16;
			end
			S_H: lane_go = 1'b1;
			default: ;
		endcase
	end

	// query datapath and result assembly
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q <= cmd;
				if (accept) res_q <= res_imm;
			end
			S_DUR2: begin
				dur_q    <= rd_key.time_v;
				w_q      <= '0;
				status_q <= ST_OK;
				res_q.status      <= ST_OK;
				res_q.out_time    <= rd_key.time_v;
				res_q.out_pos_x   <= rd_key.pos[0];
				res_q.out_pos_y   <= rd_key.pos[1];
				res_q.out_pos_z   <= rd_key.pos[2];
				res_q.out_scale_x <= rd_key.scale[0];
				res_q.out_scale_y <= rd_key.scale[1];
				res_q.out_scale_z <= rd_key.scale[2];
				res_q.out_tension <= rd_key.ten;
			end
			S_MOD:  if (div_done) w_q <= ws;
			S_SRCH: k_q <= srch_k;
			S_F2:   e1_q <= rd_key;
			S_F3:   e2_q <= rd_key;
			S_F4:   e0_q <= rd_key;
			S_F5: begin
				e3_q <= rd_key;
				if (zero_c) begin
					status_q <= ST_ZERO;
					u_q      <= '0;
				end else if (diff <= 0) begin
					u_q <= '0;
				end else if (!frac_go) begin
					u_q <= ONE_Q16;
				end
			end
			S_FRAC: if (div_done) u_q <= {1'b0, div_quo};
			S_SQ: begin
				sq_q  <= 34'(x_sq * x_sq);
				btp_q <= dten * $signed({1'b0, u_q});
			end
			S_CUBE: begin
				u3_q <= 51'(sq_q * u_q);
				f_q  <= $signed(f_c);
			end
			S_H: begin
				coef_q <= coef_d;
				tp_q   <= dten * f_q;
			end
			S_LANE: begin
				if (lane_done[0]) begin
					res_q.status      <= status_q;
					res_q.out_time    <= sat32(56'(w_q));
					res_q.out_pos_x   <= lane_pos[0];
					res_q.out_pos_y   <= lane_pos[1];
					res_q.out_pos_z   <= lane_pos[2];
					res_q.out_scale_x <= lane_scl[0];
					res_q.out_scale_y <= lane_scl[1];
					res_q.out_scale_z <= lane_scl[2];
					res_q.out_tension <= 16'(tk18 + 18'(tp_q >>> 16));
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= MODE_LINEAR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) mode_q <= cfg_wdata;
			done_q <= (accept && !(cmd.func == FUNC_INTERP && count != '0)) ||
			          (state_q == S_DUR2 && count == CNT_W'(1)) ||
			          (state_q == S_LANE && lane_done[0]);
		end
	end

endmodule
